[hdl/elk_pkg.sv]
// ---------------------------------------------------------------------------
// elk_pkg
// shared types, key codes and constants of the escape key line editor
// ---------------------------------------------------------------------------
package elk_pkg;

   localparam int LINE_MAX_DEFAULT = 64;

   localparam int CHAR_W    = 7;
   localparam int KEY_W     = 8;
   localparam int IDX_W     = 6;
   localparam int OUT_LEN_W = 6;
   localparam int EVENT_W   = 3;

   // transaction kinds
   localparam logic OP_KEY  = 1'b0;
   localparam logic OP_READ = 1'b1;

   // control keys
   localparam logic [KEY_W-1:0] KEY_HOME    = 8'd1;
   localparam logic [KEY_W-1:0] KEY_LEFT    = 8'd2;
   localparam logic [KEY_W-1:0] KEY_CTRL_C  = 8'd3;
   localparam logic [KEY_W-1:0] KEY_CTRL_D  = 8'd4;
   localparam logic [KEY_W-1:0] KEY_END     = 8'd5;
   localparam logic [KEY_W-1:0] KEY_RIGHT   = 8'd6;
   localparam logic [KEY_W-1:0] KEY_BELL    = 8'd7;
   localparam logic [KEY_W-1:0] KEY_BS      = 8'd8;
   localparam logic [KEY_W-1:0] KEY_TAB     = 8'd9;
   localparam logic [KEY_W-1:0] KEY_LF      = 8'd10;
   localparam logic [KEY_W-1:0] KEY_CTRL_K  = 8'd11;
   localparam logic [KEY_W-1:0] KEY_CTRL_L  = 8'd12;
   localparam logic [KEY_W-1:0] KEY_ENTER   = 8'd13;
   localparam logic [KEY_W-1:0] KEY_HDOWN   = 8'd14;
   localparam logic [KEY_W-1:0] KEY_CTRL_O  = 8'd15;
   localparam logic [KEY_W-1:0] KEY_HUP     = 8'd16;
   localparam logic [KEY_W-1:0] KEY_QUIT    = 8'd17;
   localparam logic [KEY_W-1:0] KEY_CTRL_R  = 8'd18;
   localparam logic [KEY_W-1:0] KEY_CTRL_S  = 8'd19;
   localparam logic [KEY_W-1:0] KEY_CTRL_T  = 8'd20;
   localparam logic [KEY_W-1:0] KEY_CLEAR   = 8'd21;
   localparam logic [KEY_W-1:0] KEY_CTRL_V  = 8'd22;
   localparam logic [KEY_W-1:0] KEY_CTRL_W  = 8'd23;
   localparam logic [KEY_W-1:0] KEY_CTRL_X  = 8'd24;
   localparam logic [KEY_W-1:0] KEY_CTRL_Y  = 8'd25;
   localparam logic [KEY_W-1:0] KEY_SUSPEND = 8'd26;
   localparam logic [KEY_W-1:0] KEY_ESC     = 8'h1b;
   localparam logic [KEY_W-1:0] KEY_DEL     = 8'd127;

   // sequence characters
   localparam logic [KEY_W-1:0] CH_BRACKET = 8'h5b;
   localparam logic [KEY_W-1:0] CH_TILDE   = 8'h7e;
   localparam logic [KEY_W-1:0] CH_ZERO    = 8'h30;
   localparam logic [KEY_W-1:0] CH_THREE   = 8'h33;
   localparam logic [KEY_W-1:0] CH_NINE    = 8'h39;
   localparam logic [KEY_W-1:0] CH_UP      = 8'h41;
   localparam logic [KEY_W-1:0] CH_DOWN    = 8'h42;
   localparam logic [KEY_W-1:0] CH_RIGHT   = 8'h43;
   localparam logic [KEY_W-1:0] CH_LEFT    = 8'h44;
   localparam logic [KEY_W-1:0] CH_BACKTAB = 8'h5a;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_FIRST,
      PH_SECOND,
      PH_THIRD
   } phase_type;

   typedef enum logic [EVENT_W-1:0] {
      EV_NONE    = 3'd0,
      EV_ENTER   = 3'd1,
      EV_QUIT    = 3'd2,
      EV_SUSPEND = 3'd3,
      EV_TAB     = 3'd4,
      EV_BACKTAB = 3'd5,
      EV_HUP     = 3'd6,
      EV_HDOWN   = 3'd7
   } event_type;

   typedef struct packed {
      logic             op;
      logic [KEY_W-1:0] key_byte;
      logic [IDX_W-1:0] read_index;
   } req_item_type;

   typedef struct packed {
      logic              insert;
      logic              remove;
      logic [CHAR_W-1:0] ch;
   } store_cmd_type;

   typedef struct packed {
      logic [OUT_LEN_W-1:0] line_length;
      logic [OUT_LEN_W-1:0] cursor;
      event_type            event_res;
      logic [CHAR_W-1:0]    read_char;
   } rsp_fields_type;

endpackage

[hdl/escape_key_line_editor.sv]
// ---------------------------------------------------------------------------
// escape_key_line_editor
// line editor for terminal key bytes with escape sequence decoding
// ---------------------------------------------------------------------------
// Takes one transaction per clock cycle while results are taken as they
// come. An accepted transaction is held in the input register, and its
// result is loaded into the result register when it is processed. The
// line is held in a row of character cells; on an insert or a delete the
// cells from the cursor upward shift together in the same cycle, so every
// key byte and every read completes in a single pass. While a finished
// result waits, the input register can take one more transaction and then
// holds req_tready low until the result is taken.
module escape_key_line_editor
   import elk_pkg::*;
#(
   parameter int LINE_MAX = LINE_MAX_DEFAULT
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // key_byte[7:0], read_index[13:8], zero
   input  logic        req_tuser,   // op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // line_length[5:0], cursor[11:6],
                                    // event_res[14:12], read_char[21:15], zero
);

   localparam int LEN_W = $clog2(LINE_MAX);

   req_item_type   in_item, s1_item;
   logic           s1_valid;
   logic           step;
   store_cmd_type  cmd;
   logic [LEN_W-1:0] edit_cursor, read_addr;
   logic           read_ok;
   logic [CHAR_W-1:0] read_data;
   rsp_fields_type rsp_in, rsp_ff;
   logic           rsp_valid_ff, rsp_valid_in;

   assign in_item.op         = req_tuser;
   assign in_item.key_byte   = req_tdata[7:0];
   assign in_item.read_index = req_tdata[13:8];

   assign step = s1_valid && (!rsp_valid_ff || rsp_tready);

   elk_input_stage u_input (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (in_item),
      .out_valid (s1_valid),
      .out_take  (step),
      .out_item  (s1_item)
   );

   elk_editor #(.LINE_MAX(LINE_MAX)) u_editor (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .item        (s1_item),
      .cmd         (cmd),
      .edit_cursor (edit_cursor),
      .read_ok     (read_ok),
      .read_addr   (read_addr),
      .line_length (rsp_in.line_length),
      .cursor      (rsp_in.cursor),
      .event_res   (rsp_in.event_res)
   );

   elk_line_store #(.LINE_MAX(LINE_MAX)) u_store (
      .clock       (clock),
      .cmd         (cmd),
      .edit_cursor (edit_cursor),
      .read_ok     (read_ok),
      .read_addr   (read_addr),
      .read_data   (read_data)
   );

   assign rsp_in.read_char = read_data;
   assign rsp_valid_in     = step || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (step) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_ff.read_char, rsp_ff.event_res,
                        rsp_ff.cursor, rsp_ff.line_length};

`ifndef SYNTHESIS
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (s1_valid && rsp_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("input accepted while both stages are held");

   a_step_result: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid_ff)
      else $error("processed transaction left no result");

   a_event_no_char: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.event_res != EV_NONE)) |-> (rsp_ff.read_char == '0))
      else $error("key event carries a read character");
`endif

endmodule

[hdl/elk_input_stage.sv]
// ---------------------------------------------------------------------------
// elk_input_stage
// input register holding one accepted transaction until it is processed
// ---------------------------------------------------------------------------
module elk_input_stage
   import elk_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  req_item_type in_item,
   output logic         out_valid,
   input  logic         out_take,
   output req_item_type out_item
);

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;
   req_item_type item_in;

   assign in_ready = !valid_ff || out_take;

   always_comb begin
      valid_in = (in_valid && in_ready) || (valid_ff && !out_take);
      item_in  = (in_valid && in_ready) ? in_item : item_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

[hdl/elk_line_store.sv]
// ---------------------------------------------------------------------------
// elk_line_store
// character cells with parallel shift for insert and delete, one read port
// ---------------------------------------------------------------------------
module elk_line_store
   import elk_pkg::*;
#(
   parameter int LINE_MAX = LINE_MAX_DEFAULT
)
(
   input  logic                        clock,
   input  store_cmd_type               cmd,
   input  logic [$clog2(LINE_MAX)-1:0] edit_cursor,
   input  logic                        read_ok,
   input  logic [$clog2(LINE_MAX)-1:0] read_addr,
   output logic [CHAR_W-1:0]           read_data
);

   localparam int LEN_W = $clog2(LINE_MAX);

   logic [CHAR_W-1:0] cells_ff [LINE_MAX];
   logic [CHAR_W-1:0] cells_in [LINE_MAX];

   always_comb begin
      for (int i = 0; i < LINE_MAX; i++) begin
         cells_in[i] = cells_ff[i];
      end
      if (cmd.insert) begin
         if (edit_cursor == '0) begin
            cells_in[0] = cmd.ch;
         end
         for (int i = 1; i < LINE_MAX; i++) begin
            if (LEN_W'(i) > edit_cursor) begin
               cells_in[i] = cells_ff[i-1];
            end else if (LEN_W'(i) == edit_cursor) begin
               cells_in[i] = cmd.ch;
            end
         end
      end else if (cmd.remove) begin
         for (int i = 0; i < LINE_MAX - 1; i++) begin
            if (LEN_W'(i + 1) >= edit_cursor) begin
               cells_in[i] = cells_ff[i+1];
            end
         end
         cells_in[LINE_MAX-1] = '0;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < LINE_MAX; i++) begin
         cells_ff[i] <= cells_in[i];
      end
   end

   // address is below the line length whenever read_ok is high
   assign read_data = read_ok ? cells_ff[read_addr] : '0;

endmodule

[hdl/elk_editor.sv]
// ---------------------------------------------------------------------------
// elk_editor
// key decode, escape sequence tracking, cursor and length bookkeeping
// ---------------------------------------------------------------------------
module elk_editor
   import elk_pkg::*;
#(
   parameter int LINE_MAX = LINE_MAX_DEFAULT
)
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  req_item_type                item,
   output store_cmd_type               cmd,
   output logic [$clog2(LINE_MAX)-1:0] edit_cursor,
   output logic                        read_ok,
   output logic [$clog2(LINE_MAX)-1:0] read_addr,
   output logic [OUT_LEN_W-1:0]        line_length,
   output logic [OUT_LEN_W-1:0]        cursor,
   output event_type                   event_res
);

   localparam int LEN_W = $clog2(LINE_MAX);
   localparam int CW    = (LEN_W > IDX_W) ? LEN_W : IDX_W;
   localparam logic [LEN_W-1:0] FILL_MAX = LEN_W'(LINE_MAX - 1);

   phase_type        phase_ff, phase_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [LEN_W-1:0] cur_ff, cur_in;
   logic [KEY_W-1:0] first_ff, first_in;
   logic [KEY_W-1:0] digit_ff, digit_in;
   logic             closed_ff, closed_in;

   logic             key_step;
   logic             is_digit;
   logic [LEN_W-1:0] len0, cur0;
   logic             ins_req, del_req, left_req, right_req;
   logic [CW-1:0]    len_ext, cur_ext, idx_ext, len_ff_ext;
   logic [KEY_W-1:0] b;

   assign b        = item.key_byte;
   assign key_step = step && (item.op == OP_KEY);
   assign is_digit = (first_ff == CH_BRACKET) && (b >= CH_ZERO) && (b <= CH_NINE);

   // escape phase next state
   always_comb begin
      phase_in = phase_ff;
      if (key_step) begin
         unique case (phase_ff)
            PH_IDLE:   if (b == KEY_ESC) phase_in = PH_FIRST;
            PH_FIRST:  phase_in = PH_SECOND;
            PH_SECOND: phase_in = is_digit ? PH_THIRD : PH_IDLE;
            PH_THIRD:  phase_in = PH_IDLE;
            default:   phase_in = PH_IDLE;
         endcase
      end
   end

   // edits and events
   always_comb begin
      len0      = len_ff;
      cur0      = cur_ff;
      closed_in = closed_ff;
      first_in  = first_ff;
      digit_in  = digit_ff;
      event_res = EV_NONE;
      ins_req   = 1'b0;
      del_req   = 1'b0;
      left_req  = 1'b0;
      right_req = 1'b0;
      cmd       = '0;
      if (key_step) begin
         if (closed_ff) begin
            closed_in = 1'b0;
            len0      = '0;
            cur0      = '0;
         end
      end
      len_in = len0;
      cur_in = cur0;
      if (key_step) begin
         unique case (phase_ff)
            PH_IDLE: begin
               unique case (b)
                  KEY_ENTER: begin
                     closed_in = 1'b1;
                     event_res = EV_ENTER;
                  end
                  KEY_QUIT: begin
                     closed_in = 1'b1;
                     event_res = EV_QUIT;
                  end
                  KEY_SUSPEND: event_res = EV_SUSPEND;
                  KEY_TAB:     event_res = EV_TAB;
                  KEY_HOME:    cur_in = '0;
                  KEY_END:     cur_in = len0;
                  KEY_CLEAR: begin
                     len_in = '0;
                     cur_in = '0;
                  end
                  KEY_BS, KEY_DEL: del_req = 1'b1;
                  KEY_HDOWN:   event_res = EV_HDOWN;
                  KEY_HUP:     event_res = EV_HUP;
                  KEY_LEFT:    left_req = 1'b1;
                  KEY_RIGHT:   right_req = 1'b1;
                  KEY_CTRL_C, KEY_CTRL_D, KEY_BELL, KEY_LF, KEY_CTRL_K, KEY_CTRL_L,
                  KEY_CTRL_O, KEY_CTRL_R, KEY_CTRL_S, KEY_CTRL_T, KEY_CTRL_V,
                  KEY_CTRL_W, KEY_CTRL_X, KEY_CTRL_Y, KEY_ESC: begin
                  end
                  default:     ins_req = !b[KEY_W-1];
               endcase
            end
            PH_FIRST: first_in = b;
            PH_SECOND: begin
               if (is_digit) begin
                  digit_in = b;
               end else if (first_ff == CH_BRACKET) begin
                  unique case (b)
                     CH_UP:      event_res = EV_HUP;
                     CH_DOWN:    event_res = EV_HDOWN;
                     CH_RIGHT:   right_req = 1'b1;
                     CH_LEFT:    left_req = 1'b1;
                     CH_BACKTAB: event_res = EV_BACKTAB;
                     default: begin
                     end
                  endcase
               end
            end
            PH_THIRD: del_req = (b == CH_TILDE) && (digit_ff == CH_THREE);
            default: begin
            end
         endcase
      end
      if (ins_req && (len0 < FILL_MAX)) begin
         cmd.insert = 1'b1;
         cmd.ch     = b[CHAR_W-1:0];
         len_in     = len0 + 1'b1;
         cur_in     = cur0 + 1'b1;
      end
      if (del_req && (cur0 != '0)) begin
         cmd.remove = 1'b1;
         len_in     = len0 - 1'b1;
         cur_in     = cur0 - 1'b1;
      end
      if (left_req && (cur0 != '0)) begin
         cur_in = cur0 - 1'b1;
      end
      if (right_req && (cur0 < len0)) begin
         cur_in = cur0 + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         len_ff    <= '0;
         cur_ff    <= '0;
         first_ff  <= '0;
         digit_ff  <= '0;
         closed_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         len_ff    <= len_in;
         cur_ff    <= cur_in;
         first_ff  <= first_in;
         digit_ff  <= digit_in;
         closed_ff <= closed_in;
      end
   end

   assign edit_cursor = cur0;
   assign len_ext     = CW'(len_in);
   assign cur_ext     = CW'(cur_in);
   assign idx_ext     = CW'(item.read_index);
   assign len_ff_ext  = CW'(len_ff);
   assign line_length = len_ext[OUT_LEN_W-1:0];
   assign cursor      = cur_ext[OUT_LEN_W-1:0];
   assign read_addr   = idx_ext[LEN_W-1:0];
   assign read_ok     = (item.op == OP_READ) && (idx_ext < len_ff_ext);

endmodule

[sim/tb_escape_key_line_editor.sv]
// ---------------------------------------------------------------------------
// tb_escape_key_line_editor
// self-checking testbench for the escape key line editor
// ---------------------------------------------------------------------------
// Drives key bytes and read requests into the request stream and checks every
// response against an in-bench model of the line, cursor and escape decoder.
// A short table of directed transactions runs first, then constrained random
// groups: mostly printable runs long enough to fill the line, control keys,
// well formed and broken escape sequences, high bytes and reads. Both stream
// sides idle at random in two of three phases; the sender drains in between.
// ---------------------------------------------------------------------------
module tb_escape_key_line_editor;
   import elk_pkg::*;

   localparam int          CYCLE_LIMIT = 200000;
   localparam int          LINE_CELLS  = LINE_MAX_DEFAULT;
   localparam logic [7:0]  CH_SS3      = 8'h4f;
   localparam logic [7:0]  CH_HOME_SEQ = 8'h48;
   localparam logic [7:0]  CH_END_SEQ  = 8'h46;

   typedef struct {
      logic           op;
      logic [7:0]     kb;
      logic [5:0]     idx;
      bit             typed;
      rsp_fields_type want;
   } dir_row_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;   // key_byte[7:0], read_index[13:8], zero
   logic        req_tuser  = 1'b0; // op
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;         // line_length[5:0], cursor[11:6],
                                   // event_res[14:12], read_char[21:15], zero

   // line model
   logic [6:0]  ln_store [LINE_CELLS];
   int          ln_len;
   int          ln_cursor;
   phase_type   ln_phase;
   logic [7:0]  ln_first;
   logic [7:0]  ln_digit;
   bit          ln_closed;

   rsp_fields_type pending_rsp [$];
   dir_row_type    dir_rows [25];
   int             snd_idle_pct = 10;
   int             rcv_idle_pct = 49;
   int             driven_items = 0;
   int             mismatches   = 0;
   int             cycle_count  = 0;

   escape_key_line_editor u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic drop_before_cursor();
      if (ln_cursor == 0) return;
      for (int i = ln_cursor - 1; i + 1 < ln_len; i++) ln_store[i] = ln_store[i + 1];
      ln_cursor--;
      ln_len--;
      ln_store[ln_len] = '0;
   endtask

   task automatic edit_line(input logic op, input logic [7:0] kb, input logic [5:0] idx,
                            output rsp_fields_type r);
      event_type  ev;
      logic [6:0] rc;
      ev = EV_NONE;
      rc = '0;
      if (op == OP_READ) begin
         if (idx < ln_len) rc = ln_store[idx];
      end else begin
         if (ln_closed) begin
            ln_closed = 1'b0;
            ln_len    = 0;
            ln_cursor = 0;
         end
         if (ln_phase == PH_IDLE) begin
            case (kb)
               KEY_ENTER: begin
                  ln_closed = 1'b1;
                  ev = EV_ENTER;
               end
               KEY_QUIT: begin
                  ln_closed = 1'b1;
                  ev = EV_QUIT;
               end
               KEY_SUSPEND: ev = EV_SUSPEND;
               KEY_TAB:     ev = EV_TAB;
               KEY_HOME:    ln_cursor = 0;
               KEY_END:     ln_cursor = ln_len;
               KEY_CLEAR: begin
                  ln_len    = 0;
                  ln_cursor = 0;
               end
               KEY_BS, KEY_DEL: drop_before_cursor();
               KEY_HDOWN: ev = EV_HDOWN;
               KEY_HUP:   ev = EV_HUP;
               KEY_LEFT:  if (ln_cursor > 0) ln_cursor--;
               KEY_RIGHT: if (ln_cursor < ln_len) ln_cursor++;
               KEY_CTRL_C, KEY_CTRL_D, KEY_BELL, KEY_LF, KEY_CTRL_K, KEY_CTRL_L,
               KEY_CTRL_O, KEY_CTRL_R, KEY_CTRL_S, KEY_CTRL_T, KEY_CTRL_V,
               KEY_CTRL_W, KEY_CTRL_X, KEY_CTRL_Y: ;
               KEY_ESC: ln_phase = PH_FIRST;
               default: begin
                  if (kb < 8'd128 && ln_len < LINE_CELLS - 1) begin
                     for (int i = ln_len; i > ln_cursor; i--) ln_store[i] = ln_store[i - 1];
                     ln_store[ln_cursor] = kb[6:0];
                     ln_cursor++;
                     ln_len++;
                  end
               end
            endcase
         end else if (ln_phase == PH_FIRST) begin
            ln_first = kb;
            ln_phase = PH_SECOND;
         end else if (ln_phase == PH_SECOND) begin
            if (ln_first == CH_BRACKET && kb >= CH_ZERO && kb <= CH_NINE) begin
               ln_digit = kb;
               ln_phase = PH_THIRD;
            end else begin
               ln_phase = PH_IDLE;
               if (ln_first == CH_BRACKET) begin
                  case (kb)
                     CH_UP:      ev = EV_HUP;
                     CH_DOWN:    ev = EV_HDOWN;
                     CH_RIGHT:   if (ln_cursor < ln_len) ln_cursor++;
                     CH_LEFT:    if (ln_cursor > 0) ln_cursor--;
                     CH_BACKTAB: ev = EV_BACKTAB;
                     default: ;
                  endcase
               end
            end
         end else begin
            ln_phase = PH_IDLE;
            if (kb == CH_TILDE && ln_digit == CH_THREE) drop_before_cursor();
         end
      end
      r.line_length = ln_len[5:0];
      r.cursor      = ln_cursor[5:0];
      r.event_res   = ev;
      r.read_char   = rc;
   endtask

   task automatic send_req(input logic op, input logic [7:0] kb, input logic [5:0] idx,
                           input bit typed, input rsp_fields_type want);
      rsp_fields_type r;
      while ($urandom_range(99) < snd_idle_pct) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {2'b00, idx, kb};
      do @(posedge clock); while (!req_tready);
      if (!(op == OP_KEY && kb >= 8'd128 && ln_phase == PH_IDLE)) driven_items++;
      edit_line(op, kb, idx, r);
      pending_rsp.push_back(typed ? want : r);
   endtask

   task automatic send_key(input logic [7:0] kb);
      send_req(OP_KEY, kb, 6'($urandom_range(63)), 1'b0, '0);
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(negedge clock) rsp_tready <= ($urandom_range(99) >= rcv_idle_pct);

   always @(posedge clock) begin
      rsp_fields_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected transaction, expected none, got %h", $time, rsp_tdata);
            mismatches++;
         end else begin
            want = pending_rsp.pop_front();
            check_field("line_length", want.line_length, rsp_tdata[5:0]);
            check_field("cursor", want.cursor, rsp_tdata[11:6]);
            check_field("event_res", want.event_res, rsp_tdata[14:12]);
            check_field("read_char", want.read_char, rsp_tdata[21:15]);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_escape_key_line_editor: FAIL");
         $finish;
      end
   end

   initial begin
      int         kind;
      int         sel;
      int         target;
      int         burst;
      int         snd_pct_of [3];
      int         rcv_pct_of [3];
      logic [7:0] tails [8];
      snd_pct_of = '{10, 49, 0};
      rcv_pct_of = '{49, 10, 0};
      tails = '{CH_RIGHT, CH_LEFT, CH_RIGHT, CH_LEFT, CH_UP, CH_DOWN, CH_BACKTAB, CH_HOME_SEQ};
      foreach (ln_store[i]) ln_store[i] = '0;
      ln_len    = 0;
      ln_cursor = 0;
      ln_phase  = PH_IDLE;
      ln_first  = '0;
      ln_digit  = '0;
      ln_closed = 1'b0;

      dir_rows = '{
         '{OP_READ, 8'hff,       6'd0,  1'b1, '{6'd0, 6'd0, EV_NONE,    7'd0}},
         '{OP_READ, 8'h00,       6'd63, 1'b1, '{6'd0, 6'd0, EV_NONE,    7'd0}},
         '{OP_KEY,  8'hff,       6'd63, 1'b1, '{6'd0, 6'd0, EV_NONE,    7'd0}},
         '{OP_KEY,  8'h80,       6'd0,  1'b1, '{6'd0, 6'd0, EV_NONE,    7'd0}},
         '{OP_KEY,  KEY_TAB,     6'd0,  1'b1, '{6'd0, 6'd0, EV_TAB,     7'd0}},
         '{OP_KEY,  KEY_SUSPEND, 6'd0,  1'b1, '{6'd0, 6'd0, EV_SUSPEND, 7'd0}},
         '{OP_KEY,  KEY_HUP,     6'd0,  1'b1, '{6'd0, 6'd0, EV_HUP,     7'd0}},
         '{OP_KEY,  KEY_HDOWN,   6'd0,  1'b1, '{6'd0, 6'd0, EV_HDOWN,   7'd0}},
         '{OP_KEY,  8'h00,       6'd0,  1'b1, '{6'd1, 6'd1, EV_NONE,    7'd0}},
         '{OP_KEY,  8'h7e,       6'd0,  1'b0, '0},
         '{OP_KEY,  KEY_LEFT,    6'd0,  1'b0, '0},
         '{OP_READ, 8'h00,       6'd1,  1'b0, '0},
         '{OP_KEY,  KEY_DEL,     6'd0,  1'b0, '0},
         '{OP_KEY,  KEY_LEFT,    6'd0,  1'b0, '0},
         '{OP_KEY,  KEY_RIGHT,   6'd0,  1'b0, '0},
         '{OP_KEY,  KEY_END,     6'd0,  1'b0, '0},
         '{OP_KEY,  KEY_ESC,     6'd0,  1'b0, '0},
         '{OP_KEY,  CH_BRACKET,  6'd0,  1'b0, '0},
         '{OP_KEY,  CH_LEFT,     6'd0,  1'b0, '0},
         '{OP_KEY,  KEY_ESC,     6'd0,  1'b0, '0},
         '{OP_KEY,  CH_BRACKET,  6'd0,  1'b0, '0},
         '{OP_KEY,  CH_THREE,    6'd0,  1'b0, '0},
         '{OP_KEY,  CH_TILDE,    6'd0,  1'b0, '0},
         '{OP_KEY,  KEY_ENTER,   6'd0,  1'b0, '0},
         '{OP_KEY,  KEY_QUIT,    6'd0,  1'b0, '0}
      };

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i])
         send_req(dir_rows[i].op, dir_rows[i].kb, dir_rows[i].idx,
                  dir_rows[i].typed, dir_rows[i].want);

      for (int ph = 0; ph < 3; ph++) begin
         snd_idle_pct = snd_pct_of[ph];
         rcv_idle_pct = rcv_pct_of[ph];
         target = driven_items + 310;
         while (driven_items < target) begin
            kind = $urandom_range(99);
            if (kind < 30) begin
               send_key(8'($urandom_range(32, 126)));
            end else if (kind < 45) begin
               send_key(kind == 44 ? KEY_DEL : 8'($urandom_range(31)));
            end else if (kind < 65) begin
               send_key(KEY_ESC);
               sel = $urandom_range(9);
               if (sel <= 6) begin
                  send_key(CH_BRACKET);
                  if ($urandom_range(2) == 0) begin
                     send_key($urandom_range(1) ? CH_THREE : 8'($urandom_range(CH_ZERO, CH_NINE)));
                     send_key($urandom_range(3) != 0 ? CH_TILDE : 8'($urandom_range(255)));
                  end else begin
                     send_key(sel == 6 ? CH_END_SEQ : tails[$urandom_range(7)]);
                  end
               end else if (sel <= 8) begin
                  send_key(CH_SS3);
                  send_key($urandom_range(1) ? CH_HOME_SEQ : CH_END_SEQ);
               end else begin
                  send_key(8'($urandom_range(255)));
                  send_key(8'($urandom_range(255)));
               end
            end else if (kind < 80) begin
               send_req(OP_READ, 8'($urandom_range(255)),
                        6'($urandom_range(3) == 0 ? $urandom_range(63) : $urandom_range(ln_len)),
                        1'b0, '0);
            end else if (kind < 85) begin
               burst = $urandom_range(10, 70);
               repeat (burst) send_key(8'($urandom_range(28, 126)));
            end else if (kind < 90) begin
               send_key(8'($urandom_range(128, 255)));
            end else if (kind < 95) begin
               send_key(KEY_ESC);
               repeat ($urandom_range(0, 3)) send_key(8'($urandom_range(255)));
            end else begin
               sel = $urandom_range(3);
               send_key(sel == 0 ? KEY_ENTER : sel == 1 ? KEY_QUIT :
                        sel == 2 ? KEY_CLEAR : 8'($urandom_range(255)));
            end
         end
         @(negedge clock);
         req_tvalid <= 1'b0;
         while (pending_rsp.size() != 0) @(posedge clock);
      end

      repeat (10) @(posedge clock);
      if (mismatches == 0)
         $display("tb_escape_key_line_editor: PASS");
      else
         $display("tb_escape_key_line_editor: FAIL");
      $finish;
   end

endmodule

[escape_key_line_editor.f]
hdl/elk_pkg.sv
hdl/elk_input_stage.sv
hdl/elk_line_store.sv
hdl/elk_editor.sv
hdl/escape_key_line_editor.sv
sim/tb_escape_key_line_editor.sv
